>>> rtl/assert_macros.svh
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion on clk_i, off while rst_ni is low
`define PSEL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication whose consequent is checked in the next cycle
`define PSEL_ASSERT_NEXT(lbl, pre, post, msg) \
  `PSEL_ASSERT(lbl, (pre) |=> (post), msg)

`endif

>>> rtl/psel_pkg.sv
// Types and constants of the peer unchoke selector
package psel_pkg;

  typedef logic [15:0] peer_key_t;
  typedef logic [31:0] rate_t;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_SELECT = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    EV_CHOKE   = 2'd0,
    EV_UNCHOKE = 2'd1,
    EV_NOCHG   = 2'd2
  } event_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND,
    ST_WRITE,
    ST_RANK,
    ST_DIV,
    ST_PLACE,
    ST_CRD,
    ST_CEV,
    ST_UNCH,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic      en;
    logic      clear;
    peer_key_t id;
    rate_t     rate;
    logic      want;
  } tbl_wr_t;

  localparam int unsigned ROUND_PERIOD = 3;
  localparam logic [3:0]  ACTIVE_RESET = 4'd4;
  localparam int unsigned PICK_W       = 8;

endpackage

>>> rtl/psel_table.sv
// Peer table: id and rate memory with valid and interested flags
module psel_table
  import psel_pkg::*;
#(
  parameter int MAX_PEERS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [$clog2(MAX_PEERS)-1:0] rd_addr_i,
  input  logic [$clog2(MAX_PEERS)-1:0] wr_addr_i,
  input  tbl_wr_t                      wr_i,
  output peer_key_t                    rd_id_o,
  output rate_t                        rd_rate_o,
  output logic [MAX_PEERS-1:0]         valid_o,
  output logic [MAX_PEERS-1:0]         intr_o
);

  logic [$bits(peer_key_t)+$bits(rate_t)-1:0] mem [MAX_PEERS];
  logic [$bits(peer_key_t)+$bits(rate_t)-1:0] rdata_q;
  logic [MAX_PEERS-1:0]                       valid_q;
  logic [MAX_PEERS-1:0]                       intr_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en && !wr_i.clear) begin
      mem[wr_addr_i] <= {wr_i.id, wr_i.rate};
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      intr_q  <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_addr_i] <= !wr_i.clear;
      intr_q[wr_addr_i]  <= wr_i.want && !wr_i.clear;
    end
  end

  assign rd_id_o   = rdata_q[$bits(peer_key_t)+$bits(rate_t)-1:$bits(rate_t)];
  assign rd_rate_o = rdata_q[$bits(rate_t)-1:0];
  assign valid_o   = valid_q;
  assign intr_o    = intr_q;

endmodule

>>> rtl/psel_ctrl.sv
// Sequencer: table search, rank passes, choke and unchoke word generation
module psel_ctrl
  import psel_pkg::*;
#(
  parameter int MAX_PEERS  = 16,
  parameter int MAX_ACTIVE = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   action_i,
  input  peer_key_t                    peer_key_i,
  input  rate_t                        rate_i,
  input  logic                         wants_upload_i,
  input  logic [PICK_W-1:0]            random_pick_i,
  input  logic                         cfg_we_i,
  input  logic [3:0]                   cfg_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output peer_key_t                    target_peer_o,
  output logic [1:0]                   event_res_o,
  output logic                         last_o,
  output logic                         tbl_rd_en_o,
  output logic [$clog2(MAX_PEERS)-1:0] tbl_rd_addr_o,
  output logic [$clog2(MAX_PEERS)-1:0] tbl_wr_addr_o,
  output tbl_wr_t                      tbl_wr_o,
  input  peer_key_t                    tbl_id_i,
  input  rate_t                        tbl_rate_i,
  input  logic [MAX_PEERS-1:0]         tbl_valid_i,
  input  logic [MAX_PEERS-1:0]         tbl_intr_i
);

  localparam int SW  = $clog2(MAX_PEERS);
  localparam int CW  = $clog2(MAX_PEERS + 1);
  localparam int AIW = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1;
  localparam int ACW = $clog2(MAX_ACTIVE + 1);
  localparam logic [4:0] MAX_A5 = 5'(MAX_ACTIVE);

  state_e state_q, state_d;

  action_e           act_q;
  peer_key_t         key_q;
  rate_t             rate_q;
  logic              want_q;
  logic [PICK_W-1:0] pick_q;
  logic [3:0]        active_q;
  logic [1:0]        phase_q;

  logic [CW-1:0] scan_idx_q;
  logic          rd_vld_q;
  logic [SW-1:0] rd_slot_q;

  logic          found_q, free_q;
  logic [SW-1:0] found_slot_q, free_slot_q;

  logic          best_vld_q;
  rate_t         best_rate_q, prev_rate_q;
  logic [SW-1:0] best_slot_q, prev_slot_q;
  peer_key_t     best_id_q;
  logic [CW-1:0] r_q, count_q;

  logic          opt_vld_q, opt_done_q;
  logic [CW-1:0] rem_q;
  logic [2:0]    div_cnt_q;
  logic [ACW-1:0] fill_q, i_q, ucount_q;

  peer_key_t chosen_q [MAX_ACTIVE];
  peer_key_t unch_mem [MAX_ACTIVE];
  peer_key_t unch_rdata_q;

  logic      pend_vld_q;
  peer_key_t pend_id_q;
  event_e    pend_ev_q;
  logic      out_vld_q;
  peer_key_t out_id_q;
  event_e    out_ev_q;
  logic      out_last_q;

  logic accept, scan_busy, pass_done, hit, cand, below_prev, above_best;
  logic pass_start, place, div_start, div_step, i_clr, i_inc;
  logic unch_rd, unch_wr, emit, flush, out_free, can_emit, kept;
  logic opt_hit, fill_ok, stop;
  peer_key_t emit_id;
  event_e    emit_ev;
  logic [ACW-1:0] size_w, limit, nchosen, fill_pos, fill_nx;
  logic [CW:0]    rem_sh, rem_nx;

  assign accept    = in_valid_i && in_ready_o;
  assign out_free  = !out_vld_q || out_ready_i;
  assign can_emit  = !pend_vld_q || out_free;
  assign scan_busy = (state_q == ST_FIND) || (state_q == ST_RANK);
  assign pass_done = (scan_idx_q == CW'(MAX_PEERS)) && !rd_vld_q;

  assign tbl_rd_en_o   = scan_busy && (scan_idx_q < CW'(MAX_PEERS));
  assign tbl_rd_addr_o = scan_idx_q[SW-1:0];

  assign hit        = rd_vld_q && tbl_valid_i[rd_slot_q] && (tbl_id_i == key_q);
  assign below_prev = (tbl_rate_i < prev_rate_q) ||
                      ((tbl_rate_i == prev_rate_q) && (rd_slot_q > prev_slot_q));
  assign above_best = tbl_rate_i > best_rate_q;
  assign cand       = rd_vld_q && tbl_valid_i[rd_slot_q] && tbl_intr_i[rd_slot_q] &&
                      ((r_q == '0) || below_prev) && (!best_vld_q || above_best);

  always_comb begin
    if (active_q == 4'd0) begin
      size_w = ACW'(1);
    end else if ({1'b0, active_q} > MAX_A5) begin
      size_w = ACW'(MAX_ACTIVE);
    end else begin
      size_w = ACW'(active_q);
    end
  end

  assign limit    = size_w - ACW'(opt_vld_q);
  assign nchosen  = fill_q + ACW'(opt_vld_q);
  assign fill_pos = fill_q + ACW'(opt_vld_q);
  assign opt_hit  = opt_vld_q && (r_q == rem_q);
  assign fill_ok  = !opt_hit && (fill_q < limit);
  assign fill_nx  = fill_ok ? fill_q + ACW'(1) : fill_q;
  assign stop     = ((fill_nx == limit) && (!opt_vld_q || opt_done_q || opt_hit)) ||
                    ((r_q + CW'(1)) == count_q);

  assign rem_sh = {rem_q, pick_q[3'(PICK_W - 1) - div_cnt_q]};
  assign rem_nx = (rem_sh >= {1'b0, count_q}) ? rem_sh - {1'b0, count_q} : rem_sh;

  always_comb begin
    kept = 1'b0;
    for (int j = 0; j < MAX_ACTIVE; j++) begin
      if ((ACW'(j) < nchosen) && (chosen_q[j] == unch_rdata_q)) begin
        kept = 1'b1;
      end
    end
  end

  always_comb begin
    tbl_wr_o       = '0;
    tbl_wr_o.id    = key_q;
    tbl_wr_o.rate  = rate_q;
    tbl_wr_o.want  = want_q;
    tbl_wr_addr_o  = found_q ? found_slot_q : free_slot_q;
    if (state_q == ST_WRITE) begin
      if (act_q == ACT_ADD) begin
        tbl_wr_o.en = found_q || free_q;
      end else if (act_q == ACT_REMOVE) begin
        tbl_wr_o.en    = found_q;
        tbl_wr_o.clear = 1'b1;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    pass_start = 1'b0;
    place      = 1'b0;
    div_start  = 1'b0;
    div_step   = 1'b0;
    i_clr      = 1'b0;
    i_inc      = 1'b0;
    unch_rd    = 1'b0;
    unch_wr    = 1'b0;
    emit       = 1'b0;
    emit_id    = unch_rdata_q;
    emit_ev    = EV_CHOKE;
    flush      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          pass_start = 1'b1;
          case (action_e'(action_i))
            ACT_SELECT:         state_d = ST_RANK;
            ACT_ADD, ACT_REMOVE: state_d = ST_FIND;
            default:            state_d = ST_WRITE;
          endcase
        end
      end
      ST_FIND: begin
        if (pass_done) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        state_d = ST_IDLE;
      end
      ST_RANK: begin
        if (pass_done) begin
          if (!best_vld_q) begin
            i_clr   = 1'b1;
            state_d = ST_CRD;
          end else if ((r_q == '0) && (phase_q == '0)) begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end else begin
            state_d = ST_PLACE;
          end
        end
      end
      ST_DIV: begin
        div_step = 1'b1;
        if (div_cnt_q == 3'(PICK_W - 1)) state_d = ST_PLACE;
      end
      ST_PLACE: begin
        place = 1'b1;
        if (stop) begin
          i_clr   = 1'b1;
          state_d = ST_CRD;
        end else begin
          pass_start = 1'b1;
          state_d    = ST_RANK;
        end
      end
      ST_CRD: begin
        if (i_q < ucount_q) begin
          unch_rd = 1'b1;
          state_d = ST_CEV;
        end else begin
          i_clr   = 1'b1;
          state_d = ST_UNCH;
        end
      end
      ST_CEV: begin
        if (kept) begin
          i_inc   = 1'b1;
          state_d = ST_CRD;
        end else if (can_emit) begin
          emit    = 1'b1;
          i_inc   = 1'b1;
          state_d = ST_CRD;
        end
      end
      ST_UNCH: begin
        if (i_q < nchosen) begin
          if (can_emit) begin
            emit    = 1'b1;
            emit_id = chosen_q[i_q[AIW-1:0]];
            emit_ev = EV_UNCHOKE;
            unch_wr = 1'b1;
            i_inc   = 1'b1;
          end
        end else begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          flush   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= ACTIVE_RESET;
      phase_q     <= '0;
      ucount_q    <= '0;
      scan_idx_q  <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      best_vld_q  <= 1'b0;
      r_q         <= '0;
      count_q     <= '0;
      opt_vld_q   <= 1'b0;
      opt_done_q  <= 1'b0;
      rem_q       <= '0;
      div_cnt_q   <= '0;
      fill_q      <= '0;
      i_q         <= '0;
      pend_vld_q  <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      if (cfg_we_i) active_q <= cfg_data_i;

      rd_vld_q <= tbl_rd_en_o;
      if (tbl_rd_en_o) scan_idx_q <= scan_idx_q + CW'(1);
      if (pass_start) begin
        scan_idx_q <= '0;
        best_vld_q <= 1'b0;
      end else if ((state_q == ST_RANK) && cand) begin
        best_vld_q <= 1'b1;
      end

      if (accept) begin
        found_q    <= 1'b0;
        free_q     <= 1'b0;
        r_q        <= '0;
        count_q    <= '0;
        opt_vld_q  <= 1'b0;
        opt_done_q <= 1'b0;
        fill_q     <= '0;
        if (action_e'(action_i) == ACT_SELECT) begin
          phase_q <= (phase_q == 2'(ROUND_PERIOD - 1)) ? '0 : phase_q + 2'd1;
        end
      end

      if (state_q == ST_FIND) begin
        if (hit) found_q <= 1'b1;
        if (rd_vld_q && !tbl_valid_i[rd_slot_q]) free_q <= 1'b1;
      end

      if ((state_q == ST_RANK) && (r_q == '0) && rd_vld_q &&
          tbl_valid_i[rd_slot_q] && tbl_intr_i[rd_slot_q]) begin
        count_q <= count_q + CW'(1);
      end

      if (div_start) begin
        opt_vld_q <= 1'b1;
        rem_q     <= '0;
        div_cnt_q <= '0;
      end else if (div_step) begin
        rem_q     <= rem_nx[CW-1:0];
        div_cnt_q <= div_cnt_q + 3'd1;
      end

      if (place) begin
        if (opt_hit) opt_done_q <= 1'b1;
        fill_q <= fill_nx;
        r_q    <= r_q + CW'(1);
      end

      if (i_clr) begin
        i_q <= '0;
      end else if (i_inc) begin
        i_q <= i_q + ACW'(1);
      end

      if (flush) ucount_q <= nchosen;

      if (emit) begin
        pend_vld_q <= 1'b1;
      end else if (flush) begin
        pend_vld_q <= 1'b0;
      end

      if ((emit && pend_vld_q) || flush) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q  <= action_e'(action_i);
      key_q  <= peer_key_i;
      rate_q <= rate_i;
      want_q <= wants_upload_i;
      pick_q <= random_pick_i;
    end
    rd_slot_q <= scan_idx_q[SW-1:0];
    if ((state_q == ST_FIND) && hit) found_slot_q <= rd_slot_q;
    if ((state_q == ST_FIND) && rd_vld_q && !tbl_valid_i[rd_slot_q] && !free_q) begin
      free_slot_q <= rd_slot_q;
    end
    if ((state_q == ST_RANK) && cand) begin
      best_rate_q <= tbl_rate_i;
      best_slot_q <= rd_slot_q;
      best_id_q   <= tbl_id_i;
    end
    if (place) begin
      prev_rate_q <= best_rate_q;
      prev_slot_q <= best_slot_q;
      if (opt_hit) begin
        chosen_q[0] <= best_id_q;
      end else if (fill_ok) begin
        chosen_q[fill_pos[AIW-1:0]] <= best_id_q;
      end
    end
    if (unch_wr) unch_mem[i_q[AIW-1:0]] <= chosen_q[i_q[AIW-1:0]];
    if (unch_rd) unch_rdata_q <= unch_mem[i_q[AIW-1:0]];
    if (emit) begin
      pend_id_q <= emit_id;
      pend_ev_q <= emit_ev;
    end
    if (emit && pend_vld_q) begin
      out_id_q   <= pend_id_q;
      out_ev_q   <= pend_ev_q;
      out_last_q <= 1'b0;
    end else if (flush) begin
      out_id_q   <= pend_vld_q ? pend_id_q : '0;
      out_ev_q   <= pend_vld_q ? pend_ev_q : EV_NOCHG;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign target_peer_o = out_id_q;
  assign event_res_o   = out_ev_q;
  assign last_o        = out_last_q;

endmodule

>>> rtl/peer_unchoke_selector_top.sv
// Top level of the peer unchoke selector
//
// Add and remove words search the peer table, one entry per cycle. A select
// word ranks interested peers by rate through repeated passes over the table
// memory, one read per cycle, each pass yielding the next peer in rank order;
// a round takes at least one pass, adds the optimistic pick on every
// ROUND_PERIOD-th select word, then a choke word per previously unchoked peer
// that is not kept and an unchoke word per new set member.
// The number of ranks is the active size, or up to the optimistic position
// when that lies further down. Results go out through a one-word output
// register; a new input word may be taken while the last result still waits.
module peer_unchoke_selector_top
  import psel_pkg::*;
#(
  parameter int MAX_PEERS  = 16,
  parameter int MAX_ACTIVE = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] action_i,
  input  logic [15:0] peer_key_i,
  input  logic [31:0] rate_i,
  input  logic       wants_upload_i,
  input  logic [7:0] random_pick_i,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [15:0] target_peer_o,
  output logic [1:0] event_res_o,
  output logic       last_o
);

  logic                         tbl_rd_en;
  logic [$clog2(MAX_PEERS)-1:0] tbl_rd_addr;
  logic [$clog2(MAX_PEERS)-1:0] tbl_wr_addr;
  tbl_wr_t                      tbl_wr;
  peer_key_t                    tbl_id;
  rate_t                        tbl_rate;
  logic [MAX_PEERS-1:0]         tbl_valid;
  logic [MAX_PEERS-1:0]         tbl_intr;

  psel_table #(
    .MAX_PEERS(MAX_PEERS)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (tbl_rd_en),
    .rd_addr_i(tbl_rd_addr),
    .wr_addr_i(tbl_wr_addr),
    .wr_i     (tbl_wr),
    .rd_id_o  (tbl_id),
    .rd_rate_o(tbl_rate),
    .valid_o  (tbl_valid),
    .intr_o   (tbl_intr)
  );

  psel_ctrl #(
    .MAX_PEERS (MAX_PEERS),
    .MAX_ACTIVE(MAX_ACTIVE)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .peer_key_i    (peer_key_i),
    .rate_i        (rate_i),
    .wants_upload_i(wants_upload_i),
    .random_pick_i (random_pick_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .target_peer_o (target_peer_o),
    .event_res_o   (event_res_o),
    .last_o        (last_o),
    .tbl_rd_en_o   (tbl_rd_en),
    .tbl_rd_addr_o (tbl_rd_addr),
    .tbl_wr_addr_o (tbl_wr_addr),
    .tbl_wr_o      (tbl_wr),
    .tbl_id_i      (tbl_id),
    .tbl_rate_i    (tbl_rate),
    .tbl_valid_i   (tbl_valid),
    .tbl_intr_i    (tbl_intr)
  );

endmodule

>>> rtl/psel_checker.sv
// Port-level checker for the peer unchoke selector, with its bind
`include "assert_macros.svh"

module psel_checker
  import psel_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  action_i,
  input logic [15:0] peer_key_i,
  input logic [31:0] rate_i,
  input logic        wants_upload_i,
  input logic [7:0]  random_pick_i,
  input logic        cfg_we_i,
  input logic [3:0]  cfg_data_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] target_peer_o,
  input logic [1:0]  event_res_o,
  input logic        last_o
);

  `PSEL_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(target_peer_o) && $stable(event_res_o) && $stable(last_o), "output word changed while stalled")
  `PSEL_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "input taken twice in a row")
  `PSEL_ASSERT(a_nochg_form, out_valid_o && (event_res_o == EV_NOCHG) |-> last_o && (target_peer_o == 16'd0), "malformed no-change word")
  `PSEL_ASSERT(a_event_code, out_valid_o |-> (event_res_o == EV_CHOKE) || (event_res_o == EV_UNCHOKE) || (event_res_o == EV_NOCHG), "bad event code")

endmodule

bind peer_unchoke_selector_top psel_checker u_psel_checker (.*);
